>>> hw/rtl/cfdl_pkg.sv
// ----------------------------------------------------------------------------
// cfdl_pkg: shared types and constants of the crossfading delay line tap
// Field widths, command and register codes, sequencer states and the tag
// that follows each tap read down the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cfdl_pkg;

  // Default geometry
  localparam int unsigned LINE_LEN_DEF  = 65536;
  localparam int unsigned BLOCK_LEN_DEF = 1024;

  // Field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned ACC_W      = 32;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned RAMP_W     = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Fixed point
  localparam int unsigned Q15_ONE  = 32768;  // unity ramp weight
  localparam int unsigned ROUND_SH = 29;     // Q1.23 * Q2.14 * Q1.15 -> Q9.23

  // Register reset values
  localparam logic                  FADE_LAW_RST  = 1'b1;
  localparam logic [DELAY_W-1:0]    MAX_DELAY_RST = 16'd64511;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_TAP   = 2'd1,
    CMD_XFADE = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FADE_LAW  = 1'b0,
    CFG_MAX_DELAY = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAP0,
    ST_TAP1,
    ST_WAIT
  } state_e;

  // Travels with each tap read through the address, memory and MAC stages
  typedef struct packed {
    logic vld;
    logic first;  // first term of the item: start from acc_in
    logic last;   // last term of the item: sum complete afterwards
    logic tap;    // 0 old tap, 1 new tap
  } tap_tag_t;

endpackage

`default_nettype wire

>>> hw/rtl/cfdl_fade_rom.sv
// ----------------------------------------------------------------------------
// cfdl_fade_rom: fade ramp ROM
// Linear and square-root Q1.15 ramps, BLOCK_LEN entries each, built at
// elaboration. One registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cfdl_fade_rom
  import cfdl_pkg::*;
#(
  parameter int unsigned BLOCK_LEN = BLOCK_LEN_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         law_i,
  input  wire logic [$clog2(BLOCK_LEN)-1:0] idx_i,
  output logic      [RAMP_W-1:0]            ramp_o
);

  localparam int unsigned BW  = $clog2(BLOCK_LEN);
  localparam int unsigned RAW = $clog2(2 * BLOCK_LEN);
  localparam longint unsigned DEN = longint'(BLOCK_LEN) - 1;

  typedef logic [RAMP_W-1:0] ramp_tbl_t [2*BLOCK_LEN];

  // lin: i/(N-1) rounded half up; root: nearest integer sqrt of floor(2^30 i/(N-1))
  function automatic ramp_tbl_t build_table();
    ramp_tbl_t       t;
    longint unsigned lin;
    longint unsigned v;
    longint unsigned r;
    longint unsigned rem;
    longint unsigned bitv;
    int unsigned     i;
    int unsigned     k;
    for (i = 0; i < BLOCK_LEN; i++) begin
      lin  = (longint'(i) * 2 * Q15_ONE + DEN) / (2 * DEN);
      v    = (longint'(i) << 30) / DEN;
      r    = 0;
      rem  = v;
      bitv = longint'(1) << 30;
      for (k = 0; k < 16; k++) begin
        if (rem >= r + bitv) begin
          rem = rem - (r + bitv);
          r   = (r >> 1) + bitv;
        end else begin
          r = r >> 1;
        end
        bitv = bitv >> 2;
      end
      if (rem > r) begin
        r = r + 1;
      end
      t[i]             = RAMP_W'(lin);
      t[BLOCK_LEN + i] = RAMP_W'(r);
    end
    return t;
  endfunction

  localparam ramp_tbl_t FADE_TBL = build_table();

  logic [RAW-1:0]    rom_addr;
  logic [RAMP_W-1:0] ramp_q;

  assign rom_addr = law_i ? (RAW'(BLOCK_LEN) + RAW'(idx_i)) : RAW'(idx_i);

  always_ff @(posedge clk_i) begin
    ramp_q <= FADE_TBL[rom_addr];
  end

  assign ramp_o = ramp_q;

endmodule

`default_nettype wire

>>> hw/rtl/cfdl_mac.sv
// ----------------------------------------------------------------------------
// cfdl_mac: tap scaling and accumulation
// gain*weight, then sample*(gain*weight), round at 2^29, accumulate onto
// acc_in, saturate to 32 bits. Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module cfdl_mac
  import cfdl_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire tap_tag_t                   tag_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic        [GAIN_W-1:0]   gain_i,
  input  wire logic        [RAMP_W-1:0]   weight_i,
  input  wire logic signed [ACC_W-1:0]    acc_i,
  input  wire logic                       clear_i,
  output logic                            done_o,
  output logic signed      [ACC_W-1:0]    acc_o,
  output logic                            sat_o
);

  localparam int unsigned GW_W   = GAIN_W + RAMP_W;
  localparam int unsigned PROD_W = SAMPLE_W + GW_W + 1;
  localparam int unsigned TERM_W = PROD_W - ROUND_SH;
  localparam int unsigned SUM_W  = ACC_W + 3;
  localparam logic signed [PROD_W-1:0] RND_BIAS = PROD_W'(1) << (ROUND_SH - 1);

  tap_tag_t                   tag_a_q, tag_b_q;
  logic                       done_q;
  logic signed [SAMPLE_W-1:0] s_a_q;
  logic        [GW_W-1:0]     gw_a_q;
  logic signed [PROD_W-1:0]   prod_b_q;
  logic signed [PROD_W-1:0]   prod_d;
  logic signed [PROD_W-1:0]   rnd_full;
  logic signed [TERM_W-1:0]   term;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic                       ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
      done_q  <= 1'b0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
      if (clear_i) begin
        done_q <= 1'b0;
      end else if (tag_b_q.vld && tag_b_q.last) begin
        done_q <= 1'b1;
      end
    end
  end

  assign prod_d   = PROD_W'(s_a_q) * PROD_W'($signed({1'b0, gw_a_q}));
  assign rnd_full = prod_b_q + RND_BIAS;
  assign term     = rnd_full[PROD_W-1:ROUND_SH];  // floor shift, halves up
  assign sum_d    = (tag_b_q.first ? SUM_W'(acc_i) : sum_q) + SUM_W'(term);

  always_ff @(posedge clk_i) begin
    s_a_q    <= sample_i;
    gw_a_q   <= GW_W'(gain_i) * GW_W'(weight_i);
    prod_b_q <= prod_d;
    if (tag_b_q.vld) begin
      sum_q <= sum_d;
    end
  end

  // Out of range when the bits above the 32-bit sign are not all copies of it
  assign ovf = (sum_q[SUM_W-1:ACC_W-1] != '0) && (sum_q[SUM_W-1:ACC_W-1] != '1);

  always_comb begin
    acc_o = sum_q[ACC_W-1:0];
    if (ovf) begin
      acc_o = sum_q[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  assign sat_o  = ovf;
  assign done_o = done_q;

endmodule

`default_nettype wire

>>> hw/rtl/crossfading_delay_line_tap.sv
// ----------------------------------------------------------------------------
// crossfading_delay_line_tap: circular delay line with crossfading tap read
// Sample memory with write pointer; single tap and two-tap crossfade reads
// scaled in fixed point and added to a saturating 32-bit accumulator.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, command_i ...     | word in
//  out     | out_valid_o, out_stall_i, acc_out_o, ...  | word out
//  cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i          | write only
//
//  Write: one word per cycle while no read is in progress. A tap or crossfade
//  read word runs through the address/memory/MAC pipeline before the next word
//  is taken; the taps of a crossfade share it one a cycle.
//  Reset: no clearing pass; entries not yet written read as zero (fill tracked
//  by write pointer plus a wrapped flag). A held result in the output register
//  does not block new words; a finished sum waits only if that register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module crossfading_delay_line_tap
  import cfdl_pkg::*;
#(
  parameter int unsigned LINE_LEN  = LINE_LEN_DEF,
  parameter int unsigned BLOCK_LEN = BLOCK_LEN_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_we_i,
  input  wire logic        [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic        [CFG_DATA_W-1:0] cfg_wdata_i,
  // input words
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic        [CMD_W-1:0]      command_i,
  input  wire logic signed [SAMPLE_W-1:0]   sample_in_i,
  input  wire logic signed [ACC_W-1:0]      acc_in_i,
  input  wire logic        [DELAY_W-1:0]    delay_old_i,
  input  wire logic        [DELAY_W-1:0]    delay_new_i,
  input  wire logic        [GAIN_W-1:0]     gain_old_i,
  input  wire logic        [GAIN_W-1:0]     gain_new_i,
  input  wire logic        [POS_W-1:0]      position_i,
  // result words
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed      [ACC_W-1:0]      acc_out_o,
  output logic                              saturated_o
);

  // --------------------------------------------------------------------------
  // Address arithmetic
  // tap address = (wp + pos - BLOCK_LEN - delay) mod LINE_LEN. A constant
  // multiple of LINE_LEN keeps the operand non-negative; the reduction is a
  // reciprocal multiply (exact for every operand below 2^Y_W) and a subtract.
  // --------------------------------------------------------------------------
  localparam int unsigned     AW      = $clog2(LINE_LEN);
  localparam int unsigned     BW      = $clog2(BLOCK_LEN);
  localparam longint unsigned WRAP_K  =
    (longint'(BLOCK_LEN) + (longint'(1) << DELAY_W) - 1 + LINE_LEN - 1) / LINE_LEN;
  localparam longint unsigned OFFS    = WRAP_K * LINE_LEN - BLOCK_LEN;
  localparam longint unsigned Y_MAX   = longint'(LINE_LEN) + BLOCK_LEN + WRAP_K * LINE_LEN;
  localparam int unsigned     Y_W     = $clog2(Y_MAX + 1);
  localparam int unsigned     RS      = Y_W + AW;
  localparam longint unsigned RECIP   = ((longint'(1) << RS) + LINE_LEN - 1) / LINE_LEN;
  localparam int unsigned     M_W     = Y_W + 1;
  localparam int unsigned     QP_W    = Y_W + M_W;
  localparam int unsigned     Q_W     = QP_W - RS;
  localparam int unsigned     PC_W    = (POS_W > BW) ? POS_W : BW;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e                     state_q, state_d;
  logic                       fade_law_q;
  logic        [DELAY_W-1:0]  max_delay_q;
  logic        [AW-1:0]       wp_q;
  logic                       wrapped_q;

  // item held for the duration of a read
  logic        [Y_W-1:0]      y0_q, y1_q;
  logic                       cross_q;
  logic        [BW-1:0]       pos_q;
  logic        [GAIN_W-1:0]   g0_q, g1_q;
  logic signed [ACC_W-1:0]    acc_q;

  // address / memory stages
  tap_tag_t                   tag_p1_q, tag_p2_q, tag_p3_q;
  logic        [Y_W-1:0]      y_p1_q;
  logic        [Q_W-1:0]      quo_q;
  logic        [AW-1:0]       addr_q;
  logic signed [SAMPLE_W-1:0] rd_q;
  logic                       wrt_q;

  // output register
  logic                       out_vld_q;
  logic signed [ACC_W-1:0]    out_acc_q;
  logic                       out_sat_q;

  logic signed [SAMPLE_W-1:0] mem [LINE_LEN];

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  logic                in_acc;
  cmd_e                cmd;
  logic [DELAY_W-1:0]  d0_clamp, d1_clamp;
  logic [BW-1:0]       pos_eff;
  logic [Y_W-1:0]      y0_d, y1_d;
  logic                wr_en;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cmd        = cmd_e'(command_i);
  assign wr_en      = in_acc && (cmd == CMD_WRITE);

  assign d0_clamp = (delay_old_i > max_delay_q) ? max_delay_q : delay_old_i;
  assign d1_clamp = (delay_new_i > max_delay_q) ? max_delay_q : delay_new_i;

  // positions past the block end pin to its last sample
  always_comb begin
    if (PC_W'(position_i) > PC_W'(BLOCK_LEN - 1)) begin
      pos_eff = BW'(BLOCK_LEN - 1);
    end else begin
      pos_eff = BW'(position_i);
    end
  end

  assign y0_d = Y_W'(wp_q) + Y_W'(pos_eff) + Y_W'(OFFS) - Y_W'(d0_clamp);
  assign y1_d = Y_W'(wp_q) + Y_W'(pos_eff) + Y_W'(OFFS) - Y_W'(d1_clamp);

  // --------------------------------------------------------------------------
  // Configuration, write pointer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_law_q  <= FADE_LAW_RST;
      max_delay_q <= MAX_DELAY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FADE_LAW:  fade_law_q  <= cfg_wdata_i[0];
        CFG_MAX_DELAY: max_delay_q <= cfg_wdata_i[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
    end else if (wr_en) begin
      if (wp_q == AW'(LINE_LEN - 1)) begin
        wp_q      <= '0;
        wrapped_q <= 1'b1;
      end else begin
        wp_q <= wp_q + 1'b1;
      end
    end
  end

  // item capture on a read accept
  always_ff @(posedge clk_i) begin
    if (in_acc && (cmd == CMD_TAP || cmd == CMD_XFADE)) begin
      y0_q    <= y0_d;
      y1_q    <= y1_d;
      cross_q <= (cmd == CMD_XFADE) && (d0_clamp != d1_clamp);
      pos_q   <= pos_eff;
      g0_q    <= gain_old_i;
      g1_q    <= gain_new_i;
      acc_q   <= acc_in_i;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: issue one tap per cycle, then wait for the sum
  // --------------------------------------------------------------------------
  tap_tag_t        iss_tag;
  logic [Y_W-1:0]  iss_y;
  logic            out_take;
  logic            out_load;
  logic            mac_done;

  assign out_take = out_vld_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    iss_tag  = '0;
    iss_y    = y0_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (cmd == CMD_TAP || cmd == CMD_XFADE)) begin
          state_d = ST_TAP0;
        end
      end
      ST_TAP0: begin
        iss_tag.vld   = 1'b1;
        iss_tag.first = 1'b1;
        iss_tag.last  = !cross_q;
        iss_tag.tap   = 1'b0;
        iss_y         = y0_q;
        state_d       = cross_q ? ST_TAP1 : ST_WAIT;
      end
      ST_TAP1: begin
        iss_tag.vld   = 1'b1;
        iss_tag.first = 1'b0;
        iss_tag.last  = 1'b1;
        iss_tag.tap   = 1'b1;
        iss_y         = y1_q;
        state_d       = ST_WAIT;
      end
      ST_WAIT: begin
        if (mac_done && (!out_vld_q || out_take)) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Address pipeline: quotient, remainder, memory read
  // --------------------------------------------------------------------------
  logic [QP_W-1:0] qprod;
  logic [Y_W-1:0]  qmul;
  logic [Y_W-1:0]  rem_w;

  assign qprod = QP_W'(iss_y) * QP_W'(RECIP);
  assign qmul  = Y_W'(quo_q) * Y_W'(LINE_LEN);
  assign rem_w = y_p1_q - qmul;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_p1_q <= '0;
      tag_p2_q <= '0;
      tag_p3_q <= '0;
    end else begin
      tag_p1_q <= iss_tag;
      tag_p2_q <= tag_p1_q;
      tag_p3_q <= tag_p2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= qprod[QP_W-1:RS];
    y_p1_q <= iss_y;
    addr_q <= rem_w[AW-1:0];
    // written entries: everything once wrapped, else below the pointer
    wrt_q  <= wrapped_q || (addr_q < wp_q);
  end

  // sample memory: one write port (input side), one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wp_q] <= sample_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[addr_q];
  end

  // fade ramp read aligned with the sample read: old tap fades out
  logic [BW-1:0]     ramp_idx;
  logic [RAMP_W-1:0] ramp;

  assign ramp_idx = tag_p2_q.tap ? pos_q : (BW'(BLOCK_LEN - 1) - pos_q);

  cfdl_fade_rom #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_rom (
    .clk_i  (clk_i),
    .law_i  (fade_law_q),
    .idx_i  (ramp_idx),
    .ramp_o (ramp)
  );

  // --------------------------------------------------------------------------
  // Scale and accumulate. A plain tap uses unity weight so both paths share
  // the 2^29 rounding.
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] p3_sample;
  logic        [RAMP_W-1:0]   p3_weight;
  logic        [GAIN_W-1:0]   p3_gain;
  logic signed [ACC_W-1:0]    mac_acc;
  logic                       mac_sat;

  assign p3_sample = wrt_q ? rd_q : '0;
  assign p3_weight = cross_q ? ramp : RAMP_W'(Q15_ONE);
  assign p3_gain   = tag_p3_q.tap ? g1_q : g0_q;

  cfdl_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (tag_p3_q),
    .sample_i (p3_sample),
    .gain_i   (p3_gain),
    .weight_i (p3_weight),
    .acc_i    (acc_q),
    .clear_i  (out_load),
    .done_o   (mac_done),
    .acc_o    (mac_acc),
    .sat_o    (mac_sat)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_acc_q <= mac_acc;
      out_sat_q <= mac_sat;
    end
  end

  assign out_valid_o = out_vld_q;
  assign acc_out_o   = out_acc_q;
  assign saturated_o = out_sat_q;

endmodule

`default_nettype wire

>>> sim/crossfading_delay_line_tap_tb.sv
// ----------------------------------------------------------------------------
// crossfading_delay_line_tap_tb: self-checking bench for the delay line tap
// Drives write, tap, crossfade and unused words with random idle cycles on
// both sides, predicts each tap sum from a local copy of the sample memory,
// write pointer and fade ramps, and checks every result word in order.
// ----------------------------------------------------------------------------
`default_nettype none

module crossfading_delay_line_tap_tb;
  import cfdl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE  = LINE_LEN_DEF;   // 65536: pointers wrap at 16 bits
  localparam int unsigned BLOCK = BLOCK_LEN_DEF;

  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 32;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int IDLE_PCT      = 31;
  localparam int MAX_REPORTS   = 10;

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [CMD_W-1:0]      command_i;
  logic [SAMPLE_W-1:0]   sample_in_i;
  logic [ACC_W-1:0]      acc_in_i;
  logic [DELAY_W-1:0]    delay_old_i;
  logic [DELAY_W-1:0]    delay_new_i;
  logic [GAIN_W-1:0]     gain_old_i;
  logic [GAIN_W-1:0]     gain_new_i;
  logic [POS_W-1:0]      position_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [ACC_W-1:0]      acc_out_o;
  logic                  saturated_o;

  crossfading_delay_line_tap u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .sample_in_i (sample_in_i),
    .acc_in_i    (acc_in_i),
    .delay_old_i (delay_old_i),
    .delay_new_i (delay_new_i),
    .gain_old_i  (gain_old_i),
    .gain_new_i  (gain_new_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .acc_out_o   (acc_out_o),
    .saturated_o (saturated_o)
  );

  always #10 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Bench control
  // --------------------------------------------------------------------------
  bit calm;          // no random idling on either side while set (hold-offs still apply)
  int hold_req;      // receiver hold-off request, picked up by the receiver
  int hold_left;
  int fail_cnt;
  int cycle_cnt;

  // --------------------------------------------------------------------------
  // Predictor state: sample memory, write pointer, ramps and registers
  // --------------------------------------------------------------------------
  typedef struct {
    logic [ACC_W-1:0] acc;
    logic             sat;
  } tap_sum_t;

  tap_sum_t              pending_sums[$];
  logic signed [SAMPLE_W-1:0] delay_mem [LINE];
  logic [DELAY_W-1:0]    wr_ptr;
  int                    words_written;
  logic [RAMP_W-1:0]     lin_ramp [BLOCK];
  logic [RAMP_W-1:0]     root_ramp [BLOCK];
  logic                  fade_sel;
  logic [DELAY_W-1:0]    max_dly;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - r - b;
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Ramps: linear rounds halves up, root rounds sqrt of a floored Q30 value
  initial begin : build_state
    longint unsigned v;
    longint unsigned r;
    for (int i = 0; i < BLOCK; i++) begin
      v = (longint'(i) << 30) / (BLOCK - 1);
      r = int_sqrt(v);
      if (v - r * r > r) r++;
      lin_ramp[i]  = RAMP_W'((longint'(i) * 2 * Q15_ONE + (BLOCK - 1)) / (2 * (BLOCK - 1)));
      root_ramp[i] = RAMP_W'(r);
    end
    foreach (delay_mem[i]) delay_mem[i] = '0;
    wr_ptr        = '0;
    words_written = 0;
    fade_sel      = FADE_LAW_RST;
    max_dly       = MAX_DELAY_RST;
  end

  // round(p / 2^sh), halves toward plus infinity
  function automatic longint round_div(longint p, int sh);
    return (p + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic [DELAY_W-1:0] tap_addr(logic [DELAY_W-1:0] d,
                                                  logic [POS_W-1:0] pos);
    return wr_ptr + DELAY_W'(pos) - DELAY_W'(BLOCK) - d;
  endfunction

  task automatic predict_word();
    longint   acc, sum, s0, s1, g0, g1, w0, w1;
    logic [DELAY_W-1:0] d0, d1;
    logic [POS_W-1:0]   pos;
    tap_sum_t res;
    case (command_i)
      CMD_WRITE: begin
        delay_mem[wr_ptr] = sample_in_i;
        wr_ptr = wr_ptr + 1'b1;
        words_written++;
      end
      CMD_TAP, CMD_XFADE: begin
        acc = longint'(signed'(acc_in_i));
        g0  = gain_old_i;
        g1  = gain_new_i;
        // a 10-bit position never passes the last slot of a 1024 block
        pos = position_i;
        d0  = (delay_old_i > max_dly) ? max_dly : delay_old_i;
        d1  = (delay_new_i > max_dly) ? max_dly : delay_new_i;
        s0  = longint'(delay_mem[tap_addr(d0, pos)]);
        if (command_i == CMD_TAP || d0 == d1) begin
          // equal delays fall back to a plain read with the old gain
          sum = acc + round_div(s0 * g0, 14);
        end else begin
          s1  = longint'(delay_mem[tap_addr(d1, pos)]);
          w0  = fade_sel ? root_ramp[BLOCK - 1 - pos] : lin_ramp[BLOCK - 1 - pos];
          w1  = fade_sel ? root_ramp[pos] : lin_ramp[pos];
          sum = acc + round_div(s0 * g0 * w0, ROUND_SH) + round_div(s1 * g1 * w1, ROUND_SH);
        end
        res.sat = 1'b1;
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        else if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        else res.sat = 1'b0;
        res.acc = sum[ACC_W-1:0];
        pending_sums.push_back(res);
      end
      default: ;  // unused command: no effect, no result
    endcase
  endtask

  // Inputs settle at the falling edge, so sampling at the rising edge is safe
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FADE_LAW:  fade_sel = cfg_wdata_i[0];
          CFG_MAX_DELAY: max_dly  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) predict_word();
    end
  end

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic note_mismatch(string field, longint want, longint got);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS)
      $display("mismatch %s: expected %0d, got %0d", field, want, got);
  endtask

  always @(posedge clk_i) begin
    tap_sum_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_sums.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("result word with nothing expected: acc_out %0d", signed'(acc_out_o));
      end else begin
        want = pending_sums.pop_front();
        if (acc_out_o !== want.acc)
          note_mismatch("acc_out", signed'(want.acc), signed'(acc_out_o));
        if (saturated_o !== want.sat)
          note_mismatch("saturated", want.sat, saturated_o);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, quiet stretches, and long hold-offs on request
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  task automatic send_word(cmd_e cmd, logic [SAMPLE_W-1:0] smp, logic [ACC_W-1:0] acc,
                           logic [DELAY_W-1:0] d_old, logic [DELAY_W-1:0] d_new,
                           logic [GAIN_W-1:0] g_old, logic [GAIN_W-1:0] g_new,
                           logic [POS_W-1:0] pos);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    command_i   <= cmd;
    sample_in_i <= smp;
    acc_in_i    <= acc;
    delay_old_i <= d_old;
    delay_new_i <= d_new;
    gain_old_i  <= g_old;
    gain_new_i  <= g_new;
    position_i  <= pos;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drop valid after the last accepted word
  task automatic go_quiet();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    go_quiet();
    while (pending_sums.size() != 0) @(posedge clk_i);
  endtask

  // writes are only issued with the block idle
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // delay that makes the tap land on the k-th newest stored sample
  function automatic logic [DELAY_W-1:0] delay_to(int k, logic [POS_W-1:0] pos);
    return DELAY_W'(k + int'(pos) - int'(BLOCK));
  endfunction

  function automatic logic [DELAY_W-1:0] pick_delay(logic [POS_W-1:0] pos);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60 && words_written > 0)
      return delay_to($urandom_range(1, (words_written > 4000) ? 4000 : words_written), pos);
    if (r < 80) return DELAY_W'($urandom);
    if (r < 90) return max_dly + DELAY_W'($urandom_range(0, 3));   // around the clamp
    return DELAY_W'($urandom_range(0, 2047));
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '1;
    if (r < 20) return GAIN_W'(16'h4000);    // unity in Q2.14
    return GAIN_W'($urandom);
  endfunction

  task automatic random_word(int write_pct);
    int r;
    cmd_e cmd;
    logic [POS_W-1:0]   pos;
    logic [DELAY_W-1:0] d0, d1;
    logic [ACC_W-1:0]   acc;
    r = $urandom_range(0, 99);
    if (r < write_pct) cmd = CMD_WRITE;
    else if (r >= 96) cmd = CMD_NOP;
    else cmd = $urandom_range(0, 1) ? CMD_TAP : CMD_XFADE;
    pos = POS_W'($urandom);
    d0  = pick_delay(pos);
    d1  = ($urandom_range(0, 99) < 15) ? d0 : pick_delay(pos);
    r   = $urandom_range(0, 99);
    // accumulator random or near either rail, so saturation is hit often
    if (r < 70) acc = $urandom;
    else if (r < 85) acc = 32'h7FFF_FFFF - $urandom_range(0, 1 << 25);
    else acc = 32'h8000_0000 + $urandom_range(0, 1 << 25);
    send_word(cmd, SAMPLE_W'($urandom), acc, d0, d1, pick_gain(), pick_gain(), pos);
  endtask

  task automatic run_random(int count, int write_pct);
    repeat (count) random_word(write_pct);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Rails of every field, every command, rounding, clamps and equal delays
  task automatic test_directed();
    // newest sample last; at position 1023, delay k-1 reads the k-th newest
    send_word(CMD_WRITE, 24'h7FFFFF, '0, '0, '0, '0, '0, '0);     // k = 6
    send_word(CMD_WRITE, 24'h800000, '0, '0, '0, '0, '0, '0);     // k = 5
    send_word(CMD_WRITE, 24'h000001, '0, '0, '0, '0, '0, '0);     // k = 4
    send_word(CMD_WRITE, 24'hFFFFFF, '0, '0, '0, '0, '0, '0);     // k = 3
    send_word(CMD_WRITE, 24'h000000, '0, '0, '0, '0, '0, '0);     // k = 2
    send_word(CMD_WRITE, 24'h400000, '0, '0, '0, '0, '0, '0);     // k = 1
    // saturate up and down
    send_word(CMD_TAP, '0, 32'h7FFF_FFFF, 16'd0, '0, '1, '0, 10'd1023);
    send_word(CMD_TAP, '0, 32'h8000_0000, 16'd4, '0, '1, '0, 10'd1023);
    send_word(CMD_TAP, '0, '0, 16'd5, '0, 16'h4000, '0, 10'd1023);
    // -1 * half LSB gain: halves round toward plus infinity
    send_word(CMD_TAP, '0, '0, 16'd2, '0, 16'h2000, '0, 10'd1023);
    send_word(CMD_TAP, '0, '0, 16'd2, '0, 16'h0001, '0, 10'd1023);
    // never-written slot reads zero
    send_word(CMD_TAP, '0, 32'd12345, 16'd0, '1, '1, '1, 10'd0);
    // equal delays act as a plain read with the old gain, then a crossfade and an unused word
    send_word(CMD_XFADE, '0, '0, 16'd2, 16'd2, 16'h4000, '1, 10'd1023);
    send_word(CMD_XFADE, '0, '0, 16'd5, 16'd4, '1, '1, 10'd1023);
    send_word(CMD_NOP, '1, '1, '1, '1, '1, '1, '1);
    // full range delays, linear then square-root law
    write_reg(CFG_MAX_DELAY, 16'hFFFF);
    write_reg(CFG_FADE_LAW, 1'b0);
    send_word(CMD_XFADE, '0, 32'd7, delay_to(1, 10'd0), delay_to(6, 10'd0), '1, '1, 10'd0);
    send_word(CMD_XFADE, '0, 32'h7FFF_FF00, delay_to(6, 10'd512), delay_to(5, 10'd512),
              '1, '1, 10'd512);
    write_reg(CFG_FADE_LAW, 1'b1);
    send_word(CMD_XFADE, '0, '0, delay_to(6, 10'd511), delay_to(1, 10'd511),
              '1, 16'h4000, 10'd511);
    // clamp to a tiny max delay
    write_reg(CFG_MAX_DELAY, 16'd3);
    send_word(CMD_TAP, '0, '0, '1, '0, 16'h4000, '0, 10'd1023);
    send_word(CMD_XFADE, '0, '0, 16'd100, 16'd200, 16'h4000, '1, 10'd1023);
    send_word(CMD_XFADE, '0, '0, 16'd1, 16'd9999, '1, '1, 10'd1023);
    send_word(CMD_TAP, '0, '0, 16'd4, '0, '1, '0, 10'd1023);
  endtask

  // Mixed traffic under both fade laws, one stretch with no idling at all
  task automatic test_fade_laws();
    write_reg(CFG_MAX_DELAY, 16'hFFFF);
    write_reg(CFG_FADE_LAW, 1'b0);
    run_random(300, 35);
    write_reg(CFG_FADE_LAW, 1'b1);
    calm = 1'b1;
    run_random(250, 35);
    calm = 1'b0;
  endtask

  // Zero and random small max delay: most taps get clamped
  task automatic test_delay_clamp();
    write_reg(CFG_MAX_DELAY, 16'd0);
    write_reg(CFG_FADE_LAW, 1'b0);
    run_random(80, 35);
    write_reg(CFG_MAX_DELAY, CFG_DATA_W'($urandom_range(1, 2000)));
    write_reg(CFG_FADE_LAW, 1'b1);
    run_random(120, 35);
  endtask

  // Receiver holds off while reads keep coming, so the block stalls its input
  task automatic test_backpressure();
    write_reg(CFG_MAX_DELAY, 16'hFFFF);
    calm     = 1'b1;
    hold_req = 400;
    run_random(50, 0);
    calm     = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_FADE_LAW;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    command_i   = CMD_NOP;
    sample_in_i = '0;
    acc_in_i    = '0;
    delay_old_i = '0;
    delay_new_i = '0;
    gain_old_i  = '0;
    gain_new_i  = '0;
    position_i  = '0;
    out_stall_i = 1'b1;
    calm        = 1'b0;
    hold_req    = 0;
    hold_left   = 0;
    fail_cnt    = 0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_fade_laws();
    test_delay_clamp();
    test_backpressure();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && pending_sums.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/cfdl_pkg.sv
hw/rtl/cfdl_fade_rom.sv
hw/rtl/cfdl_mac.sv
hw/rtl/crossfading_delay_line_tap.sv
sim/crossfading_delay_line_tap_tb.sv
